FILE: rtl/sss_pkg.sv
`default_nettype none
package sss_pkg;

  // Default width of the statement length and excess counters.
  localparam int COUNT_WIDTH_DEF = 32;

  // Configuration register fields.
  localparam int MAX_LEN_W    = 31;
  localparam int CFG_DATA_W   = 31;
  localparam int CFG_INDEX_W  = 1;
  localparam int EXCESS_W     = 32;

  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 31'd33554432;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LEN  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PARALLEL = 1'b1;

  // Prefix lengths.
  localparam logic [3:0] LOCK_LEN   = 4'd12;
  localparam logic [3:0] INSERT_LEN = 4'd11;

  // Special characters.
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BTICK  = 8'h60;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef enum logic [1:0] {
    Q_NONE   = 2'd0,
    Q_SINGLE = 2'd1,
    Q_DOUBLE = 2'd2,
    Q_BACK   = 2'd3
  } quote_t;

  typedef enum logic [1:0] {
    CLS_SKIP     = 2'd0,
    CLS_PARALLEL = 2'd1,
    CLS_SERIAL   = 2'd2
  } stmt_class_t;

  // One result as it moves to the output register.
  typedef struct packed {
    logic [7:0]          data;
    logic                keep;
    logic                eos;
    stmt_class_t         cls;
    logic                ovf;
    logic [EXCESS_W-1:0] excess;
  } result_t;

  // Character of "LOCK TABLES " at a position.
  function automatic logic [7:0] lock_char(input logic [3:0] pos);
    logic [7:0] ch;
    unique case (pos)
      4'd0:    ch = "L";
      4'd1:    ch = "O";
      4'd2:    ch = "C";
      4'd3:    ch = "K";
      4'd4:    ch = " ";
      4'd5:    ch = "T";
      4'd6:    ch = "A";
      4'd7:    ch = "B";
      4'd8:    ch = "L";
      4'd9:    ch = "E";
      4'd10:   ch = "S";
      4'd11:   ch = " ";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Character of "INSERT INTO" at a position.
  function automatic logic [7:0] insert_char(input logic [3:0] pos);
    logic [7:0] ch;
    unique case (pos)
      4'd0:    ch = "I";
      4'd1:    ch = "N";
      4'd2:    ch = "S";
      4'd3:    ch = "E";
      4'd4:    ch = "R";
      4'd5:    ch = "T";
      4'd6:    ch = " ";
      4'd7:    ch = "I";
      4'd8:    ch = "N";
      4'd9:    ch = "T";
      4'd10:   ch = "O";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Quote class of a byte, none when it is no quote.
  function automatic quote_t quote_of(input logic [7:0] ch);
    quote_t q;
    if (ch == CH_SQUOTE) begin
      q = Q_SINGLE;
    end else if (ch == CH_DQUOTE) begin
      q = Q_DOUBLE;
    end else if (ch == CH_BTICK) begin
      q = Q_BACK;
    end else begin
      q = Q_NONE;
    end
    return q;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/sss_cfg.sv
`default_nettype none
module sss_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_wr_en,
  input  wire logic [sss_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [sss_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic      [sss_pkg::MAX_LEN_W-1:0]      max_len,
  output logic                                    parallel_en
);

  logic [sss_pkg::MAX_LEN_W-1:0] max_len_r;
  logic                          parallel_en_r;

  // Register writes; both registers come out of reset at their defaults.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r     <= sss_pkg::MAX_LEN_RESET;
      parallel_en_r <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        sss_pkg::CFG_MAX_LEN:  max_len_r     <= cfg_data;
        sss_pkg::CFG_PARALLEL: parallel_en_r <= cfg_data[0];
        default:               ;
      endcase
    end
  end

  assign max_len     = max_len_r;
  assign parallel_en = parallel_en_r;

endmodule
`default_nettype wire

FILE: rtl/sss_core.sv
`default_nettype none
module sss_core #(
  parameter int COUNT_WIDTH = sss_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           advance,
  input  wire logic [7:0]                     data_byte,
  input  wire logic [sss_pkg::MAX_LEN_W-1:0]  max_len,
  input  wire logic                           parallel_en,
  output sss_pkg::result_t                    result
);

  localparam int CMP_W = (COUNT_WIDTH > sss_pkg::MAX_LEN_W) ? COUNT_WIDTH
                                                            : sss_pkg::MAX_LEN_W;

  logic                   at_start_r,     at_start_nxt;
  sss_pkg::quote_t        quote_r,        quote_nxt;
  logic                   escape_r,       escape_nxt;
  logic [COUNT_WIDTH-1:0] len_r,          len_nxt;
  logic [COUNT_WIDTH-1:0] excess_r,       excess_nxt;
  logic [3:0]             pos_r,          pos_nxt;
  logic                   lock_alive_r,   lock_alive_nxt;
  logic                   ins_alive_r,    ins_alive_nxt;

  logic                   blank;
  logic                   drop;
  logic                   over;
  logic                   eos;
  logic                   lock_hit;
  logic                   ins_hit;
  logic [COUNT_WIDTH-1:0] len_inc;
  logic [COUNT_WIDTH-1:0] exc_inc;
  logic [3:0]             pos_inc;
  logic                   lock_ok;
  logic                   ins_ok;
  logic [sss_pkg::EXCESS_W-1:0] excess_sat;
  sss_pkg::quote_t        byte_quote;

  // Byte classification.
  assign blank = (data_byte == sss_pkg::CH_SPACE) ||
                 ((data_byte >= sss_pkg::CH_TAB) && (data_byte <= sss_pkg::CH_CR));
  assign drop  = at_start_r && blank;
  assign byte_quote = sss_pkg::quote_of(data_byte);

  // Saturating length and excess counters.
  always_comb begin
    len_inc = (len_r != '1) ? len_r + 1'b1 : len_r;
    over    = (CMP_W'(len_inc) > CMP_W'(max_len)) || (excess_r != '0);
    exc_inc = (over && (excess_r != '1)) ? excess_r + 1'b1 : excess_r;
  end

  // Prefix matching, one character per byte until the longer prefix is done.
  always_comb begin
    lock_ok = lock_alive_r;
    ins_ok  = ins_alive_r;
    pos_inc = pos_r;
    if (pos_r < sss_pkg::LOCK_LEN) begin
      lock_ok = lock_alive_r && (data_byte == sss_pkg::lock_char(pos_r));
      if (pos_r < sss_pkg::INSERT_LEN) begin
        ins_ok = ins_alive_r && (data_byte == sss_pkg::insert_char(pos_r));
      end
      pos_inc = pos_r + 4'd1;
    end
  end

  assign eos      = !drop && (quote_r == sss_pkg::Q_NONE) && (data_byte == sss_pkg::CH_SEMI);
  assign lock_hit = lock_ok && (pos_inc >= sss_pkg::LOCK_LEN);
  assign ins_hit  = ins_ok && (pos_inc >= sss_pkg::INSERT_LEN);

  // Excess count as reported on the 32-bit port.
  generate
    if (COUNT_WIDTH > sss_pkg::EXCESS_W) begin : g_sat
      assign excess_sat = (|exc_inc[COUNT_WIDTH-1:sss_pkg::EXCESS_W]) ? '1
                          : exc_inc[sss_pkg::EXCESS_W-1:0];
    end else if (COUNT_WIDTH == sss_pkg::EXCESS_W) begin : g_same
      assign excess_sat = exc_inc;
    end else begin : g_ext
      assign excess_sat = {{(sss_pkg::EXCESS_W-COUNT_WIDTH){1'b0}}, exc_inc};
    end
  endgenerate

  // Next state of the statement scanner.
  always_comb begin
    at_start_nxt   = at_start_r;
    quote_nxt      = quote_r;
    escape_nxt     = escape_r;
    len_nxt        = len_r;
    excess_nxt     = excess_r;
    pos_nxt        = pos_r;
    lock_alive_nxt = lock_alive_r;
    ins_alive_nxt  = ins_alive_r;
    if (!drop) begin
      at_start_nxt   = 1'b0;
      len_nxt        = len_inc;
      excess_nxt     = exc_inc;
      pos_nxt        = pos_inc;
      lock_alive_nxt = lock_ok;
      ins_alive_nxt  = ins_ok;
      if (eos) begin
        at_start_nxt   = 1'b1;
        len_nxt        = '0;
        excess_nxt     = '0;
        pos_nxt        = '0;
        lock_alive_nxt = 1'b1;
        ins_alive_nxt  = 1'b1;
      end else if (quote_r == sss_pkg::Q_NONE) begin
        quote_nxt = byte_quote;
      end else if (escape_r) begin
        escape_nxt = 1'b0;
      end else if (data_byte == sss_pkg::CH_BSLASH) begin
        escape_nxt = 1'b1;
      end else if (byte_quote == quote_r) begin
        quote_nxt = sss_pkg::Q_NONE;
      end
    end
  end

  // Result fields; the end-only fields read zero on other bytes.
  always_comb begin
    result.data   = data_byte;
    result.keep   = !drop;
    result.eos    = eos;
    result.cls    = sss_pkg::CLS_SKIP;
    result.ovf    = 1'b0;
    result.excess = '0;
    if (eos) begin
      if (lock_hit) begin
        result.cls = sss_pkg::CLS_SKIP;
      end else if (parallel_en && ins_hit) begin
        result.cls = sss_pkg::CLS_PARALLEL;
      end else begin
        result.cls = sss_pkg::CLS_SERIAL;
      end
      result.ovf    = (exc_inc != '0);
      result.excess = excess_sat;
    end
  end

  // State registers advance once per request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_start_r   <= 1'b1;
      quote_r      <= sss_pkg::Q_NONE;
      escape_r     <= 1'b0;
      len_r        <= '0;
      excess_r     <= '0;
      pos_r        <= '0;
      lock_alive_r <= 1'b1;
      ins_alive_r  <= 1'b1;
    end else if (advance) begin
      at_start_r   <= at_start_nxt;
      quote_r      <= quote_nxt;
      escape_r     <= escape_nxt;
      len_r        <= len_nxt;
      excess_r     <= excess_nxt;
      pos_r        <= pos_nxt;
      lock_alive_r <= lock_alive_nxt;
      ins_alive_r  <= ins_alive_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/sss_out_reg.sv
`default_nettype none
module sss_out_reg (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire sss_pkg::result_t result_in,
  input  wire logic             out_stall,
  output logic                  ready,
  output logic                  out_valid,
  output sss_pkg::result_t      result_out
);

  logic             valid_r, valid_nxt;
  sss_pkg::result_t data_r;

  // The register can take a new result when empty or being drained.
  assign ready = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result_in;
    end
  end

  assign out_valid  = valid_r;
  assign result_out = data_r;

endmodule
`default_nettype wire

FILE: rtl/sql_statement_splitter.sv
// An accepted byte goes to the input register, then is scanned into the output register.
// Throughput: one byte per cycle unless stalled; the state updates in one step per byte.
// An input register and an output register let one more byte enter while a result waits.
// Reset (rst_n low, synchronous) empties both registers, restores the configuration
// defaults and returns the scanner to the start of a statement outside any string.
`default_nettype none
module sql_statement_splitter #(
  parameter int COUNT_WIDTH = sss_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [7:0]                      in_data_byte,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [7:0]                           out_byte,
  output logic                                 out_keep,
  output logic                                 out_end_of_statement,
  output logic [1:0]                           out_statement_class,
  output logic                                 out_overflowed,
  output logic [sss_pkg::EXCESS_W-1:0]         out_excess_bytes,
  input  wire logic                            cfg_wr_en,
  input  wire logic [sss_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [sss_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic                          in_valid_r, in_valid_nxt;
  logic [7:0]                    in_byte_r;
  logic                          out_ready;
  logic                          advance;
  logic                          accept;
  logic [sss_pkg::MAX_LEN_W-1:0] max_len;
  logic                          parallel_en;
  sss_pkg::result_t              result;
  sss_pkg::result_t              result_q;

  // Input register handshake.
  assign advance  = in_valid_r && out_ready;
  assign in_stall = in_valid_r && !out_ready;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (accept) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte_r <= in_data_byte;
    end
  end

  sss_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .max_len     (max_len),
    .parallel_en (parallel_en)
  );

  sss_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .data_byte   (in_byte_r),
    .max_len     (max_len),
    .parallel_en (parallel_en),
    .result      (result)
  );

  sss_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .result_in  (result),
    .out_stall  (out_stall),
    .ready      (out_ready),
    .out_valid  (out_valid),
    .result_out (result_q)
  );

  // Result fields onto the ports.
  assign out_byte             = result_q.data;
  assign out_keep             = result_q.keep;
  assign out_end_of_statement = result_q.eos;
  assign out_statement_class  = result_q.cls;
  assign out_overflowed       = result_q.ovf;
  assign out_excess_bytes     = result_q.excess;

endmodule
`default_nettype wire

FILE: rtl/sss_checker.sv
`default_nettype none
module sss_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic [7:0]                   out_byte,
  input wire logic                         out_keep,
  input wire logic                         out_end_of_statement,
  input wire logic [1:0]                   out_statement_class,
  input wire logic                         out_overflowed,
  input wire logic [sss_pkg::EXCESS_W-1:0] out_excess_bytes
);

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) &&
      $stable(out_end_of_statement) && $stable(out_excess_bytes))
    else $error("stalled result changed");

  // A statement ends only on a kept semicolon.
  a_end_semi: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_statement |-> out_keep && (out_byte == sss_pkg::CH_SEMI))
    else $error("end of statement on a byte other than a kept semicolon");

  // End-only fields are zero on other bytes.
  a_mid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_end_of_statement |->
      (out_statement_class == sss_pkg::CLS_SKIP) && !out_overflowed &&
      (out_excess_bytes == '0))
    else $error("end fields set on a byte inside a statement");

  // The overflow flag agrees with the excess count.
  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_statement |-> (out_overflowed == (out_excess_bytes != '0)))
    else $error("overflow flag disagrees with excess count");

  // The class code is never the unused code.
  a_cls: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_statement_class <= sss_pkg::CLS_SERIAL))
    else $error("unused statement class");

endmodule

bind sql_statement_splitter sss_checker u_sss_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_byte             (out_byte),
  .out_keep             (out_keep),
  .out_end_of_statement (out_end_of_statement),
  .out_statement_class  (out_statement_class),
  .out_overflowed       (out_overflowed),
  .out_excess_bytes     (out_excess_bytes)
);
`default_nettype wire
